// ----- sv/hpws_pkg.sv -----
// shared types and constants for the heading pid waypoint steering block
package hpws_pkg;

   // stream payload widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   // action codes carried in req_tuser
   localparam logic [1:0] ACT_ARM     = 2'd0;
   localparam logic [1:0] ACT_HEADING = 2'd1;
   localparam logic [1:0] ACT_FIX     = 2'd2;

   // register indexes on the csr port
   localparam logic [2:0] CFG_GAIN_P    = 3'd0;
   localparam logic [2:0] CFG_GAIN_I    = 3'd1;
   localparam logic [2:0] CFG_GAIN_D    = 3'd2;
   localparam logic [2:0] CFG_PERIOD    = 3'd3;
   localparam logic [2:0] CFG_RATE      = 3'd4;
   localparam logic [2:0] CFG_MAX_TURN  = 3'd5;
   localparam logic [2:0] CFG_TOLERANCE = 3'd6;

   // fixed point constants
   localparam logic        [11:0] CRUISE_SPEED  = 12'd2048;
   localparam logic signed [15:0] FULL_TURN_64  = 16'sd23040;
   localparam logic signed [17:0] DEG64_TO_RAD  = 18'sd73204;
   localparam logic signed [16:0] PI_Q12        = 17'sd12868;
   localparam logic signed [16:0] TWO_PI_Q12    = 17'sd25736;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL_TGT,
      OP_ERR,
      OP_WRAP,
      OP_MUL_INT,
      OP_MUL_DER,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_SUM
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TGT,
      ST_ERR,
      ST_WRAP,
      ST_INT,
      ST_DER,
      ST_P,
      ST_I,
      ST_D,
      ST_SUM,
      ST_OUT,
      ST_STOP
   } ctrl_state_type;

   typedef struct packed {
      logic      arm;
      logic      load_yaw;
      logic      capture;
      dp_op_type op;
      logic      emit_run;
      logic      emit_stop;
   } dp_cmd_type;

   typedef struct packed {
      logic armed;
      logic near;
      logic out_free;
   } dp_status_type;

endpackage

// ----- sv/heading_pid_waypoint_steer.sv -----
// heading pid waypoint steering controller, top level
// flow: arm and heading beats are taken in idle and give no result; a fix within
//   tolerance steps through the stop state, a steering fix through the tgt, err,
//   wrap, int, der, p, i, d, sum and out states; rsp stalls hold stop and out
// sharing: one fix at a time on the single 32x18 multiplier, six products in turn
// reset: synchronous, clears armed, yaw, integral, previous error and rsp_tvalid,
//   and loads the register defaults
module heading_pid_waypoint_steer import hpws_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // yaw_angle, bearing_deg, target_distance
   input  logic [1:0]            req_tuser,  // action
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // linear_speed, angular_rate
   output logic [0:0]            rsp_tuser,  // arrived
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [23:0]           csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   logic        [11:0] linear_speed;
   logic signed [15:0] angular_rate;
   logic               arrived;

   // registers are plain flops, always ready for a write beat
   assign csr_ready = 1'b1;

   // sequencer: decodes the action of each accepted beat and steps the datapath
   hpws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // datapath: field slices of the input beat go straight in
   hpws_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .yaw_angle       ($signed(req_tdata[14:0])),
      .bearing_deg     (req_tdata[29:15]),
      .target_distance (req_tdata[53:30]),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .linear_speed    (linear_speed),
      .angular_rate    (angular_rate),
      .arrived         (arrived)
   );

   // pack the result beat, zero pad to whole bytes
   assign rsp_tdata = {4'd0, angular_rate, linear_speed};
   assign rsp_tuser = arrived;

`ifndef SYNTH
   // a stop beat carries zero speed and zero rate
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[27:0] == 28'd0)
      else $error("stop beat with nonzero payload");

   // a steering beat carries the cruise speed
   a_run_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[11:0] == CRUISE_SPEED)
      else $error("steering beat without cruise speed");

   // results are loaded only when the output register can take them
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit_run || dp_cmd.emit_stop |-> dp_status.out_free)
      else $error("result overwrote a pending beat");

   // arrival disarms the controller
   a_stop_disarm: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit_stop |=> !dp_status.armed)
      else $error("still armed after arrival");
`endif

endmodule

// ----- sv/hpws_ctrl.sv -----
// sequencer for the steering datapath
module hpws_ctrl import hpws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    action,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (action)
                  ACT_ARM:     cmd.arm = 1'b1;
                  ACT_HEADING: cmd.load_yaw = 1'b1;
                  ACT_FIX: begin
                     if (status.armed) begin
                        cmd.capture = 1'b1;
                        state_in    = status.near ? ST_STOP : ST_TGT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_TGT:  begin cmd.op = OP_MUL_TGT; state_in = ST_ERR;  end
         ST_ERR:  begin cmd.op = OP_ERR;     state_in = ST_WRAP; end
         ST_WRAP: begin cmd.op = OP_WRAP;    state_in = ST_INT;  end
         ST_INT:  begin cmd.op = OP_MUL_INT; state_in = ST_DER;  end
         ST_DER:  begin cmd.op = OP_MUL_DER; state_in = ST_P;    end
         ST_P:    begin cmd.op = OP_MUL_P;   state_in = ST_I;    end
         ST_I:    begin cmd.op = OP_MUL_I;   state_in = ST_D;    end
         ST_D:    begin cmd.op = OP_MUL_D;   state_in = ST_SUM;  end
         ST_SUM:  begin cmd.op = OP_SUM;     state_in = ST_OUT;  end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.emit_run = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_STOP: begin
            if (status.out_free) begin
               cmd.emit_stop = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- sv/hpws_dp.sv -----
// steering datapath: state, config registers, shared multiplier, output register
module hpws_dp import hpws_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic signed [14:0] yaw_angle,
   input  logic        [14:0] bearing_deg,
   input  logic        [23:0] target_distance,
   input  logic               csr_write,
   input  logic        [2:0]  csr_index,
   input  logic        [23:0] csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [11:0] linear_speed,
   output logic signed [15:0] angular_rate,
   output logic               arrived
);

   // configuration
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff, period_ff, rate_ff;
   logic [14:0] max_turn_ff;
   logic [23:0] tolerance_ff;

   // controller state
   logic               armed_ff;
   logic signed [14:0] yaw_ff;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [15:0] prev_ff;

   // working registers
   logic        [14:0] bearing_ff;
   logic signed [49:0] prod_ff;
   logic signed [16:0] err_ff, err_in;
   logic signed [25:0] deriv_ff;
   logic signed [50:0] sum_ff, sum_in;

   // output register
   logic               rsp_valid_ff;
   logic        [11:0] speed_ff;
   logic signed [15:0] rate_out_ff;
   logic               arrived_ff;

   logic signed [31:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [49:0] mul_p;
   logic signed [15:0] tgt64;
   logic signed [49:0] rnd16, rnd8;
   logic signed [15:0] tgt_rad;
   logic signed [32:0] isum;
   logic signed [17:0] diff;
   logic signed [50:0] rnd14, lim, clamped;

   function automatic logic signed [16:0] wrap_step(input logic signed [16:0] e);
      if (e >= PI_Q12) begin
         wrap_step = e - TWO_PI_Q12;
      end else if (e < -PI_Q12) begin
         wrap_step = e + TWO_PI_Q12;
      end else begin
         wrap_step = e;
      end
   endfunction

   assign tgt64   = FULL_TURN_64 - $signed({1'b0, bearing_ff});
   assign rnd16   = (prod_ff + 50'sd32768) >>> 16;
   assign rnd8    = (prod_ff + 50'sd128) >>> 8;
   assign tgt_rad = rnd16[15:0];
   assign isum    = {integ_ff[31], integ_ff} + rnd16[32:0];
   assign diff    = {err_ff[16], err_ff} - {{2{prev_ff[15]}}, prev_ff};
   assign rnd14   = (sum_ff + 51'sd8192) >>> 14;
   assign lim     = $signed({36'd0, max_turn_ff});

   // saturate the integral to 32 bits
   always_comb begin
      if (isum[32] != isum[31]) begin
         integ_in = isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         integ_in = isum[31:0];
      end
   end

   always_comb begin
      if (rnd14 > lim) begin
         clamped = lim;
      end else if (rnd14 < -lim) begin
         clamped = -lim;
      end else begin
         clamped = rnd14;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_TGT: begin
            mul_a = {{16{tgt64[15]}}, tgt64};
            mul_b = DEG64_TO_RAD;
         end
         OP_MUL_INT: begin
            mul_a = {{15{err_ff[16]}}, err_ff};
            mul_b = $signed({2'b00, period_ff});
         end
         OP_MUL_DER: begin
            mul_a = {{14{diff[17]}}, diff};
            mul_b = $signed({2'b00, rate_ff});
         end
         OP_MUL_P: begin
            mul_a = {{15{err_ff[16]}}, err_ff};
            mul_b = $signed({2'b00, gain_p_ff});
         end
         OP_MUL_I: begin
            mul_a = integ_ff;
            mul_b = $signed({2'b00, gain_i_ff});
         end
         OP_MUL_D: begin
            mul_a = {{6{deriv_ff[25]}}, deriv_ff};
            mul_b = $signed({2'b00, gain_d_ff});
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      err_in = err_ff;
      sum_in = sum_ff;
      case (cmd.op) inside
         OP_ERR:   err_in = {tgt_rad[15], tgt_rad} - {{2{yaw_ff[14]}}, yaw_ff};
         OP_WRAP:  err_in = wrap_step(wrap_step(err_ff));
         OP_MUL_I: sum_in = {prod_ff[49], prod_ff};
         OP_MUL_D, OP_SUM: sum_in = sum_ff + {prod_ff[49], prod_ff};
         default: ;
      endcase
   end

   // payload working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      err_ff  <= err_in;
      sum_ff  <= sum_in;
      if (cmd.capture) begin
         bearing_ff <= bearing_deg;
      end
      if (cmd.op == OP_MUL_P) begin
         deriv_ff <= rnd8[25:0];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= 16'd3277;
         gain_i_ff    <= 16'd0;
         gain_d_ff    <= 16'd819;
         period_ff    <= 16'd6554;
         rate_ff      <= 16'd2560;
         max_turn_ff  <= 15'd819;
         tolerance_ff <= 24'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            CFG_GAIN_P:    gain_p_ff    <= csr_wdata[15:0];
            CFG_GAIN_I:    gain_i_ff    <= csr_wdata[15:0];
            CFG_GAIN_D:    gain_d_ff    <= csr_wdata[15:0];
            CFG_PERIOD:    period_ff    <= csr_wdata[15:0];
            CFG_RATE:      rate_ff      <= csr_wdata[15:0];
            CFG_MAX_TURN:  max_turn_ff  <= csr_wdata[14:0];
            CFG_TOLERANCE: tolerance_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // steering state
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         yaw_ff   <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         if (cmd.arm) begin
            armed_ff <= 1'b1;
         end
         if (cmd.load_yaw) begin
            yaw_ff <= yaw_angle;
         end
         if (cmd.op == OP_MUL_DER) begin
            integ_ff <= integ_in;
            prev_ff  <= err_ff[15:0];
         end
         if (cmd.emit_stop) begin
            armed_ff <= 1'b0;
            integ_ff <= '0;
            prev_ff  <= '0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_run || cmd.emit_stop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_run) begin
         speed_ff    <= CRUISE_SPEED;
         rate_out_ff <= clamped[15:0];
         arrived_ff  <= 1'b0;
      end else if (cmd.emit_stop) begin
         speed_ff    <= '0;
         rate_out_ff <= '0;
         arrived_ff  <= 1'b1;
      end
   end

   assign status.armed    = armed_ff;
   assign status.near     = (target_distance <= tolerance_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign linear_speed = speed_ff;
   assign angular_rate = rate_out_ff;
   assign arrived      = arrived_ff;

endmodule

// ----- verif/steer_checker.sv -----
// scoreboard for the heading pid steering block: predicts command beats and checks rsp
`timescale 1ns / 100ps
module steer_checker import hpws_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // yaw_angle, bearing_deg, target_distance
   input  logic [1:0]            req_tuser,   // action
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // linear_speed, angular_rate
   input  logic [0:0]            rsp_tuser,   // arrived
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [23:0]           csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [11:0]        speed;
      logic signed [15:0] turn;
      logic               arrived;
   } steer_cmd_type;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   logic [15:0]   gain_p, gain_i, gain_d, period_cfg, rate_cfg;
   logic [14:0]   turn_limit;
   logic [23:0]   tolerance;
   bit            steering;
   longint        yaw_now, err_sum, last_err;
   steer_cmd_type expected_cmds[$];

   // round half up, then drop s fraction bits
   function automatic longint round_shr(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic void predict_command(input logic [1:0] act,
                                           input logic signed [14:0] yaw,
                                           input logic [14:0] brg,
                                           input logic [23:0] distance);
      longint        tgt, err, integ, deriv, sum;
      steer_cmd_type cmd;
      cmd = '0;
      case (act)
         ACT_ARM: steering = 1'b1;
         ACT_HEADING: yaw_now = longint'(yaw);
         ACT_FIX: if (steering) begin
            if (distance <= tolerance) begin
               // arrival: stop and forget the loop history, yaw stays
               steering = 1'b0;
               err_sum  = 0;
               last_err = 0;
               cmd.arrived = 1'b1;
            end else begin
               tgt = round_shr((longint'(FULL_TURN_64) - longint'(brg))
                               * longint'(DEG64_TO_RAD), 16);
               err = tgt - yaw_now;
               while (err >= PI_Q12) err -= TWO_PI_Q12;
               while (err < -PI_Q12) err += TWO_PI_Q12;
               integ = err_sum + round_shr(err * longint'(period_cfg), 16);
               if (integ > SAT_HI) integ = SAT_HI;
               if (integ < SAT_LO) integ = SAT_LO;
               err_sum = integ;
               deriv = round_shr((err - last_err) * longint'(rate_cfg), 8);
               last_err = err;
               sum = longint'(gain_p) * err + longint'(gain_i) * integ
                     + longint'(gain_d) * deriv;
               sum = round_shr(sum, 14);
               if (sum > longint'(turn_limit)) sum = longint'(turn_limit);
               if (sum < -longint'(turn_limit)) sum = -longint'(turn_limit);
               cmd.speed = CRUISE_SPEED;
               cmd.turn  = 16'(sum);
            end
            expected_cmds.push_back(cmd);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      steer_cmd_type got, want;
      if (reset) begin
         gain_p     = 16'd3277;
         gain_i     = 16'd0;
         gain_d     = 16'd819;
         period_cfg = 16'd6554;
         rate_cfg   = 16'd2560;
         turn_limit = 15'd819;
         tolerance  = 24'd256;
         steering   = 1'b0;
         yaw_now    = 0;
         err_sum    = 0;
         last_err   = 0;
         expected_cmds.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CFG_GAIN_P:    gain_p     = csr_wdata[15:0];
               CFG_GAIN_I:    gain_i     = csr_wdata[15:0];
               CFG_GAIN_D:    gain_d     = csr_wdata[15:0];
               CFG_PERIOD:    period_cfg = csr_wdata[15:0];
               CFG_RATE:      rate_cfg   = csr_wdata[15:0];
               CFG_MAX_TURN:  turn_limit = csr_wdata[14:0];
               CFG_TOLERANCE: tolerance  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_command(req_tuser, req_tdata[14:0], req_tdata[29:15], req_tdata[53:30]);
         if (rsp_tvalid && rsp_tready) begin
            got.speed   = rsp_tdata[11:0];
            got.turn    = rsp_tdata[27:12];
            got.arrived = rsp_tuser[0];
            if (expected_cmds.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected rsp beat speed %0d turn %0d arrived %0d",
                           $time, got.speed, got.turn, got.arrived);
            end else begin
               want = expected_cmds.pop_front();
               if (got.speed != want.speed || got.turn != want.turn
                   || got.arrived != want.arrived) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: rsp mismatch, expected speed %0d turn %0d arrived %0d,",
                               " got speed %0d turn %0d arrived %0d"}, $time,
                              want.speed, want.turn, want.arrived,
                              got.speed, got.turn, got.arrived);
               end
            end
         end
      end
      pending = expected_cmds.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// top of the steering testbench: clock, reset, stimulus, rsp stalls and verdict
`timescale 1ns / 100ps
module tb_top;
   import hpws_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;   // spare action code, block drops it
   localparam int         ITEM_TARGET = 1300;
   localparam int         PHASES      = 6;
   localparam int         SETTLE      = 24;     // settle time after a drain
   localparam int         LONG_HOLD   = 400;
   localparam int         CYCLE_LIMIT = 800000;

   typedef enum int {SET_DEFAULT, SET_MAX, SET_MIN, SET_RANDOM} setting_kind_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_RHYTHM} ready_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // yaw_angle, bearing_deg, target_distance
   logic [1:0]            req_tuser;   // action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // linear_speed, angular_rate
   logic [0:0]            rsp_tuser;   // arrived
   logic                  csr_valid;
   logic                  csr_ready;
   logic [2:0]            csr_index;
   logic [23:0]           csr_wdata;

   int          fail_count;
   int          pending;
   int          burst_left;      // beats left in the current sender burst
   int          live_items;      // arm, heading and fix beats sent
   int          hold_requests;   // long rsp hold-offs asked of the receiver
   logic [23:0] tol_now;         // arrival tolerance as last written

   heading_pid_waypoint_steer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   steer_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // hard stop in case the block hangs
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // one req beat; called and returning at a falling edge, tvalid left high
   // so back-to-back beats inside a burst need no lowering of tvalid
   task automatic send_beat(input logic [1:0] act, input logic [14:0] yaw,
                            input logic [14:0] brg, input logic [23:0] distance);
      if (burst_left == 0) begin
         // gap between bursts, then a fresh burst length
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_tuser  = act;
      req_tdata  = {2'b00, distance, brg, yaw};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // unused fields carry random junk, the block must ignore them
   task automatic send_arm();
      live_items++;
      send_beat(ACT_ARM, 15'($urandom), 15'($urandom), 24'($urandom));
   endtask

   task automatic send_heading(input logic [14:0] yaw);
      live_items++;
      send_beat(ACT_HEADING, yaw, 15'($urandom), 24'($urandom));
   endtask

   task automatic send_fix(input logic [14:0] brg, input logic [23:0] distance);
      live_items++;
      send_beat(ACT_FIX, 15'($urandom), brg, distance);
   endtask

   // sender pause until every predicted rsp beat has come back
   task automatic drain();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
   endtask

   // idle point for register writes: drained plus the block's own latency
   task automatic quiesce();
      drain();
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_settings(input setting_kind_type kind);
      logic [15:0] kp, ki, kd, per, rt;
      logic [14:0] mt;
      logic [23:0] tl;
      case (kind)
         SET_DEFAULT: begin
            kp = 16'd3277; ki = 16'd0; kd = 16'd819; per = 16'd6554; rt = 16'd2560;
            mt = 15'd819; tl = 24'd256;
         end
         SET_MAX: begin
            kp = '1; ki = '1; kd = '1; per = '1; rt = '1; mt = '1;
            tl = 24'($urandom_range(0, 4096));
         end
         SET_MIN: begin
            // zero period and rate switch the integral and derivative terms off
            kp = '0; ki = '0; kd = '0; per = '0; rt = '0; mt = '0; tl = '0;
         end
         default: begin
            kp  = 16'($urandom);
            ki  = $urandom_range(0, 1) ? 16'($urandom_range(0, 256)) : 16'($urandom);
            kd  = 16'($urandom);
            per = 16'($urandom);
            rt  = 16'($urandom);
            mt  = 15'($urandom);
            tl  = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65536));
         end
      endcase
      write_reg(CFG_GAIN_P, 24'(kp));
      write_reg(CFG_GAIN_I, 24'(ki));
      write_reg(CFG_GAIN_D, 24'(kd));
      write_reg(CFG_PERIOD, 24'(per));
      write_reg(CFG_RATE, 24'(rt));
      write_reg(CFG_MAX_TURN, 24'(mt));
      write_reg(CFG_TOLERANCE, tl);
      tol_now = tl;
   endtask

   // yaw mostly within +-pi, now and then any 15 bit pattern
   function automatic logic [14:0] pick_yaw();
      if ($urandom_range(0, 19) == 0) return 15'($urandom);
      return 15'(int'($urandom_range(0, 25736)) - 12868);
   endfunction

   // bearing mostly in range, sometimes at or above a full turn
   function automatic logic [14:0] pick_bearing();
      if ($urandom_range(0, 19) == 0) return 15'($urandom_range(23040, 32767));
      return 15'($urandom_range(0, 23039));
   endfunction

   // distance beyond the tolerance: keeps steering, unless the tolerance is at its top
   function automatic logic [23:0] pick_far();
      int unsigned span;
      if (tol_now == 24'hFFFFFF) return tol_now;
      span = 32'hFFFFFF - tol_now - 1;
      if ($urandom_range(0, 7) == 0) return 24'(tol_now + 1 + $urandom_range(0, span));
      return 24'(tol_now + 1 + $urandom_range(0, (span < 4095) ? span : 4095));
   endfunction

   // distance at or inside the tolerance: arrival
   function automatic logic [23:0] pick_near();
      if ($urandom_range(0, 3) == 0) return tol_now;
      return 24'($urandom_range(0, tol_now));
   endfunction

   // one waypoint leg: arm, headings and fixes, usually ending on arrival
   task automatic run_route();
      int steps, pick;
      steps = $urandom_range(1, 24);
      send_arm();
      if ($urandom_range(0, 1)) send_heading(pick_yaw());
      repeat (steps) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) send_heading(pick_yaw());
         else if (pick < 31) send_beat(ACT_UNUSED, 15'($urandom), 15'($urandom), 24'($urandom));
         else if (pick < 34) send_arm();
         else send_fix(pick_bearing(), pick_far());
      end
      if ($urandom_range(0, 4) != 0) begin
         send_fix(pick_bearing(), pick_near());
         // stray fix after the stop, block is disarmed
         if ($urandom_range(0, 3) == 0) send_fix(pick_bearing(), pick_far());
      end
      if ($urandom_range(0, 9) == 0) drain();
   endtask

   // receiver: random stall patterns per segment, long hold-offs on request
   initial begin : rsp_stall
      int             holds_done, seg_len, tick;
      ready_mode_type mode;
      holds_done = 0;
      rsp_tready = 1'b1;
      forever begin
         if (hold_requests > holds_done) begin
            // block backs up while the sender keeps offering beats
            holds_done++;
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         mode    = ready_mode_type'($urandom_range(0, 3));
         seg_len = $urandom_range(8, 120);
         for (tick = 0; tick < seg_len; tick++) begin
            case (mode)
               READY_ALWAYS: rsp_tready = 1'b1;
               READY_COIN:   rsp_tready = 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_tready = ($urandom_range(0, 3) == 0);
               default:      rsp_tready = (tick % 4 != 3);
            endcase
            @(negedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      int phase_items;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = ACT_ARM;
      csr_valid     = 1'b0;
      csr_index     = CFG_GAIN_P;
      csr_wdata     = '0;
      burst_left    = 0;
      live_items    = 0;
      hold_requests = 0;
      tol_now       = 24'd256;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed part at reset settings
      send_fix(15'd0, 24'hFFFFFF);                  // fix before any arm
      send_beat(ACT_UNUSED, '1, '1, '1);            // spare action code
      send_arm();
      send_heading(15'(12868));                     // yaw at +pi
      send_fix(15'd0, 24'hFFFFFF);                  // bearing and distance extremes
      send_fix(15'd23039, 24'd257);                 // just past tolerance
      send_heading(15'(-12868));                    // yaw at -pi
      send_fix(15'd32767, 24'd257);                 // bearing above a full turn
      send_fix(15'd11520, 24'd1000);
      send_heading(15'd0);
      send_fix(15'd0, 24'd256);                     // exactly at tolerance: stop
      send_fix(15'd5000, 24'd5000);                 // disarmed after the stop
      send_arm();
      send_fix(15'd17280, 24'd0);                   // zero distance: stop

      // gains and clamp at their top, integral and derivative steps at zero
      quiesce();
      write_reg(CFG_GAIN_P, 24'hFFFF);
      write_reg(CFG_GAIN_I, 24'hFFFF);
      write_reg(CFG_GAIN_D, 24'hFFFF);
      write_reg(CFG_PERIOD, 24'd0);
      write_reg(CFG_RATE, 24'd0);
      write_reg(CFG_MAX_TURN, 24'h7FFF);
      send_arm();
      send_heading(15'h7FFF);
      send_fix(15'd0, 24'd1000);
      send_fix(15'd23039, 24'd1000);
      send_fix(15'd11520, 24'd1000);

      // zero clamp and widest tolerance: every fix is an arrival
      quiesce();
      write_reg(CFG_MAX_TURN, 24'd0);
      write_reg(CFG_TOLERANCE, 24'hFFFFFF);
      tol_now = 24'hFFFFFF;
      send_fix(15'd100, 24'd1000);
      send_arm();
      send_fix(15'd0, 24'hFFFFFF);

      // random legs, one register setting per phase
      for (int ph = 0; ph < PHASES; ph++) begin
         quiesce();
         load_settings((ph < 3) ? setting_kind_type'(ph) : SET_RANDOM);
         phase_items = live_items;
         run_route();
         if (ph == 1 || ph == 4) hold_requests++;
         while (live_items - phase_items < ITEM_TARGET / PHASES) run_route();
      end

      drain();
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
